### design/mh2_pkg.sv
// mh2_pkg: constants, types and codes shared by the MurmurHash2 stream core.
// No dependencies; used by all design modules through scoped names.

package mh2_pkg;

   localparam logic [31:0] MIX_MUL     = 32'h5bd1_e995;
   localparam int          MIX_SHIFT   = 24;
   localparam int          FIN_SHIFT_A = 13;
   localparam int          FIN_SHIFT_B = 15;
   localparam logic [31:0] SEED_RESET  = 32'd97;

   localparam int QUEUE_DEPTH = 4;

   localparam int   CSR_ADDR_W        = 3;
   localparam logic CSR_IDX_HASH_SEED = 1'b0;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_TAIL = 2'd1,
      KIND_FULL = 2'd2
   } word_kind_type;

   typedef struct packed {
      word_kind_type kind;
      logic          start;
      logic          last;
      logic [30:0]   length;
      logic [31:0]   data;
   } entry_type;

endpackage

### design/mh2_front.sv
// mh2_front: accepts items, classifies the word and pre-mixes full words.
// Two registered stages, one multiplier each. Depends on mh2_pkg.

module mh2_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [31:0]        req_key_word,
   input  logic [2:0]         req_byte_count,
   input  logic               req_key_start,
   input  logic [30:0]        req_key_length,
   input  logic               req_key_last,
   output logic               ent_valid,
   output mh2_pkg::entry_type ent,
   input  logic               ent_full
);

   logic               s1_valid_ff, s1_valid_in;
   mh2_pkg::entry_type s1_ff, s1_in;
   logic               s2_valid_ff, s2_valid_in;
   mh2_pkg::entry_type s2_ff, s2_in;
   logic               s1_ready, s2_ready;
   logic [31:0]        byte_mask;
   logic [31:0]        shuffled;

   assign s2_ready = !s2_valid_ff || !ent_full;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign full     = !s1_ready;

   always_comb begin
      case (req_byte_count)
         3'd1:    byte_mask = 32'h0000_00ff;
         3'd2:    byte_mask = 32'h0000_ffff;
         3'd3:    byte_mask = 32'h00ff_ffff;
         default: byte_mask = 32'h0000_0000;
      endcase
   end

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_in         = s1_ff;
      if (s1_ready) begin
         s1_valid_in   = push;
         s1_in.start   = req_key_start;
         s1_in.last    = req_key_last;
         s1_in.length  = req_key_length;
         if (req_byte_count >= 3'd4) begin
            s1_in.kind = mh2_pkg::KIND_FULL;
            s1_in.data = req_key_word * mh2_pkg::MIX_MUL;
         end else if (req_byte_count != 3'd0) begin
            s1_in.kind = mh2_pkg::KIND_TAIL;
            s1_in.data = req_key_word & byte_mask;
         end else begin
            s1_in.kind = mh2_pkg::KIND_NONE;
            s1_in.data = 32'd0;
         end
      end
   end

   assign shuffled = s1_ff.data ^ (s1_ff.data >> mh2_pkg::MIX_SHIFT);

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_in       = s2_ff;
      if (s2_ready) begin
         s2_valid_in = s1_valid_ff;
         s2_in       = s1_ff;
         if (s1_ff.kind == mh2_pkg::KIND_FULL) begin
            s2_in.data = shuffled * mh2_pkg::MIX_MUL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   assign ent_valid = s2_valid_ff;
   assign ent       = s2_ff;

endmodule

### design/mh2_fifo.sv
// mh2_fifo: short queue of classified entries between front and back.
// Flip-flop storage, one read port at the head. Depends on mh2_pkg.

module mh2_fifo #(
   parameter int QUEUE_DEPTH = mh2_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   input  mh2_pkg::entry_type wr_entry,
   output logic               q_full,
   input  logic               rd_pop,
   output logic               q_empty,
   output mh2_pkg::entry_type rd_entry
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   mh2_pkg::entry_type entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr, do_rd;

   assign q_full   = (count_ff == FULL_CNT);
   assign q_empty  = (count_ff == '0);
   assign do_wr    = wr_valid && !q_full;
   assign do_rd    = rd_pop && !q_empty;
   assign rd_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   property p_count_bound;
      @(posedge clock) disable iff (reset) count_ff <= FULL_CNT;
   endproperty
   a_count_bound: assert property (p_count_bound)
      else $error("queue count above depth");

endmodule

### design/mh2_back.sv
// mh2_back: running-hash sequencer, finalization and result register.
// One shared multiplier; takes entries from mh2_fifo. Depends on mh2_pkg.

module mh2_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [31:0]        hash_seed,
   input  logic               q_empty,
   input  mh2_pkg::entry_type q_entry,
   output logic               q_pop,
   input  logic               pop,
   output logic               empty,
   output logic [31:0]        rsp_hash_value
);

   typedef enum logic [2:0] {
      ST_MIX  = 3'b001,
      ST_FIN1 = 3'b010,
      ST_FIN2 = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [31:0]    h_ff, h_in;
   logic           out_valid_ff, out_valid_in;
   logic [31:0]    out_hash_ff, out_hash_in;
   logic [31:0]    h0, mul_a, prod, mix_res, fin_res;

   assign q_pop = (state_ff == ST_MIX) && !q_empty;

   assign h0 = q_entry.start ? (hash_seed ^ {1'b0, q_entry.length}) : h_ff;

   always_comb begin
      if (state_ff == ST_FIN1) begin
         mul_a = h_ff ^ (h_ff >> mh2_pkg::FIN_SHIFT_A);
      end else if (q_entry.kind == mh2_pkg::KIND_TAIL) begin
         mul_a = h0 ^ q_entry.data;
      end else begin
         mul_a = h0;
      end
   end

   assign prod    = mul_a * mh2_pkg::MIX_MUL;
   assign fin_res = h_ff ^ (h_ff >> mh2_pkg::FIN_SHIFT_B);

   always_comb begin
      case (q_entry.kind)
         mh2_pkg::KIND_FULL: mix_res = prod ^ q_entry.data;
         mh2_pkg::KIND_TAIL: mix_res = prod;
         default:            mix_res = h0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      h_in         = h_ff;
      out_valid_in = out_valid_ff && !pop;
      out_hash_in  = out_hash_ff;
      unique case (state_ff)
         ST_MIX: begin
            if (!q_empty) begin
               h_in = mix_res;
               if (q_entry.last) begin
                  state_in = ST_FIN1;
               end
            end
         end
         ST_FIN1: begin
            h_in     = prod;
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            if (!out_valid_ff || pop) begin
               h_in         = fin_res;
               out_hash_in  = fin_res;
               out_valid_in = 1'b1;
               state_in     = ST_MIX;
            end
         end
         default: state_in = ST_MIX;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_MIX;
         h_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         h_ff         <= h_in;
         out_valid_ff <= out_valid_in;
      end
      out_hash_ff <= out_hash_in;
   end

   assign empty          = !out_valid_ff;
   assign rsp_hash_value = out_hash_ff;

   property p_fin_order;
      @(posedge clock) disable iff (reset) state_ff == ST_FIN1 |=> state_ff == ST_FIN2;
   endproperty
   a_fin_order: assert property (p_fin_order)
      else $error("finalization skipped a step");

   property p_load_from_fin;
      @(posedge clock) disable iff (reset) $rose(out_valid_ff) |-> $past(state_ff == ST_FIN2);
   endproperty
   a_load_from_fin: assert property (p_load_from_fin)
      else $error("result loaded outside finalization");

   property p_hash_hold;
      @(posedge clock) disable iff (reset)
         (state_ff == ST_MIX && q_empty) |=> $stable(h_ff);
   endproperty
   a_hash_hold: assert property (p_hash_hold)
      else $error("running hash changed without an item");

   property p_pop_result;
      @(posedge clock) disable iff (reset)
         (out_valid_ff && pop && state_ff != ST_FIN2) |=> !out_valid_ff;
   endproperty
   a_pop_result: assert property (p_pop_result)
      else $error("result repeated after pop");

endmodule

### design/murmur2_hash_stream_core.sv
// murmur2_hash_stream_core: streaming 32-bit MurmurHash2, top level.
// Instantiates mh2_front, mh2_fifo and mh2_back; holds the seed register.
//
// Usage: a key arrives as little-endian words, one item per push. The first
// item carries req_key_start and the key length; the item with req_key_last
// produces one hash on the result side (rsp_hash_value while empty is low,
// taken with pop). An item with one to three bytes is folded in as a tail.
// Throughput: one item per cycle while keys run and full stays low; each last
// item adds two finalization steps in the back sequencer for the final
// avalanche (one shared multiplier). Between accepting a one-word key and
// empty going low lie the second front mixing stage, the queue, the mix step
// and two finalization steps. If pop stays low the result register holds,
// the back waits in finalization, the queue fills and full rises. Reset
// empties the pipeline, the queue and the result register, clears the running
// hash and sets hash_seed to 97. The seed is written over the APB port at
// byte address 0; users must do so only while idle; the block has no check.

module murmur2_hash_stream_core #(
   parameter int QUEUE_DEPTH = mh2_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [31:0]                    req_key_word,
   input  logic [2:0]                     req_byte_count,
   input  logic                           req_key_start,
   input  logic [30:0]                    req_key_length,
   input  logic                           req_key_last,
   output logic                           empty,
   input  logic                           pop,
   output logic [31:0]                    rsp_hash_value,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mh2_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   logic [31:0]        seed_ff, seed_in;
   logic               csr_wr;
   logic               ent_valid, ent_full;
   mh2_pkg::entry_type ent;
   logic               q_empty, q_pop;
   mh2_pkg::entry_type q_entry;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      seed_in = seed_ff;
      if (csr_wr && paddr[2] == mh2_pkg::CSR_IDX_HASH_SEED) begin
         seed_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= mh2_pkg::SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   assign prdata = (paddr[2] == mh2_pkg::CSR_IDX_HASH_SEED) ? seed_ff : 32'd0;

   mh2_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_key_word   (req_key_word),
      .req_byte_count (req_byte_count),
      .req_key_start  (req_key_start),
      .req_key_length (req_key_length),
      .req_key_last   (req_key_last),
      .ent_valid      (ent_valid),
      .ent            (ent),
      .ent_full       (ent_full)
   );

   mh2_fifo #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (ent_valid),
      .wr_entry (ent),
      .q_full   (ent_full),
      .rd_pop   (q_pop),
      .q_empty  (q_empty),
      .rd_entry (q_entry)
   );

   mh2_back u_back (
      .clock          (clock),
      .reset          (reset),
      .hash_seed      (seed_ff),
      .q_empty        (q_empty),
      .q_entry        (q_entry),
      .q_pop          (q_pop),
      .pop            (pop),
      .empty          (empty),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule
